@@ design/jsu_pkg.sv @@
`default_nettype none

package jsu_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Error codes carried with a result of kind error
  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_NO_OPEN_QUOTE = 3'd1,
    ERR_CONTROL_CHAR  = 3'd2,
    ERR_UNTERM_ESCAPE = 3'd3,
    ERR_SHORT_UNICODE = 3'd4,
    ERR_BAD_UNICODE   = 3'd5,
    ERR_BAD_ESCAPE    = 3'd6,
    ERR_UNTERMINATED  = 3'd7
  } err_e;

  // Decoder phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_BODY = 5'b00010,
    PH_ESC  = 5'b00100,
    PH_HEX  = 5'b01000,
    PH_ERR  = 5'b10000
  } phase_e;

  // Most results one request can produce, and the result queue size
  localparam int unsigned MaxResults = 3;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueIdxW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    err_e       error_kind;
    logic       last;
  } result_t;

  // Results produced by one request, in order from index 0
  typedef struct packed {
    logic [1:0]                     count;
    result_t [MaxResults-1:0]       res;
  } dec_out_t;

endpackage

`default_nettype wire

@@ design/jsu_decode.sv @@
`default_nettype none

module jsu_decode
  import jsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_input_i,
  output dec_out_t        dec_o
);

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;

  phase_e      phase_q, phase_d;
  logic [1:0]  hex_count_q, hex_count_d;
  logic [15:0] code_point_q, code_point_d;
  logic        hex_bad_q, hex_bad_d;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp_new;
  logic        bad_new;

  // Hex digit value, both cases
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (data_byte_i >= 8'h30 && data_byte_i <= 8'h39) begin
      hex_val = 4'(data_byte_i - 8'h30);
    end else if (data_byte_i >= 8'h61 && data_byte_i <= 8'h66) begin
      hex_val = 4'(data_byte_i - 8'h57);
    end else if (data_byte_i >= 8'h41 && data_byte_i <= 8'h46) begin
      hex_val = 4'(data_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_new  = hex_ok ? {code_point_q[11:0], hex_val} : code_point_q;
  assign bad_new = hex_bad_q | ~hex_ok;

  // Next state and results for the current request
  always_comb begin
    phase_d      = phase_q;
    hex_count_d  = hex_count_q;
    code_point_d = code_point_q;
    hex_bad_d    = hex_bad_q;
    dec_o        = '0;
    for (int i = 0; i < MaxResults; i++) begin
      dec_o.res[i].kind       = KIND_BYTE;
      dec_o.res[i].error_kind = ERR_NONE;
    end

    case (phase_q)
      PH_BODY: begin
        dec_o.count       = 2'd1;
        dec_o.res[0].last = 1'b1;
        if (end_of_input_i) begin
          dec_o.res[0].kind       = KIND_ERROR;
          dec_o.res[0].error_kind = ERR_UNTERMINATED;
          phase_d                 = PH_IDLE;
        end else if (data_byte_i == ChQuote) begin
          dec_o.res[0].kind = KIND_CLOSE;
          phase_d           = PH_IDLE;
        end else if (data_byte_i < 8'h20) begin
          dec_o.res[0].kind       = KIND_ERROR;
          dec_o.res[0].error_kind = ERR_CONTROL_CHAR;
          phase_d                 = PH_ERR;
        end else if (data_byte_i == ChBslash) begin
          dec_o.count = 2'd0;
          phase_d     = PH_ESC;
        end else begin
          dec_o.res[0].out_byte = data_byte_i;
        end
      end

      PH_ESC: begin
        dec_o.count       = 2'd1;
        dec_o.res[0].last = 1'b1;
        phase_d           = PH_BODY;
        if (end_of_input_i) begin
          dec_o.res[0].kind       = KIND_ERROR;
          dec_o.res[0].error_kind = ERR_UNTERM_ESCAPE;
          phase_d                 = PH_IDLE;
        end else begin
          case (data_byte_i)
            ChQuote:  dec_o.res[0].out_byte = ChQuote;
            ChBslash: dec_o.res[0].out_byte = ChBslash;
            ChSlash:  dec_o.res[0].out_byte = ChSlash;
            8'h62:    dec_o.res[0].out_byte = 8'h08;
            8'h66:    dec_o.res[0].out_byte = 8'h0C;
            8'h6E:    dec_o.res[0].out_byte = 8'h0A;
            8'h72:    dec_o.res[0].out_byte = 8'h0D;
            8'h74:    dec_o.res[0].out_byte = 8'h09;
            8'h75: begin
              dec_o.count  = 2'd0;
              phase_d      = PH_HEX;
              hex_count_d  = 2'd0;
              code_point_d = '0;
              hex_bad_d    = 1'b0;
            end
            default: begin
              dec_o.res[0].kind       = KIND_ERROR;
              dec_o.res[0].error_kind = ERR_BAD_ESCAPE;
              phase_d                 = PH_ERR;
            end
          endcase
        end
      end

      PH_HEX: begin
        if (end_of_input_i) begin
          dec_o.count             = 2'd1;
          dec_o.res[0].last       = 1'b1;
          dec_o.res[0].kind       = KIND_ERROR;
          dec_o.res[0].error_kind = ERR_SHORT_UNICODE;
          phase_d                 = PH_IDLE;
        end else begin
          code_point_d = cp_new;
          hex_bad_d    = bad_new;
          if (hex_count_q != 2'd3) begin
            hex_count_d = hex_count_q + 2'd1;
          end else begin
            hex_count_d = 2'd0;
            // Reject bad digits and surrogates, else encode as UTF-8
            if (bad_new || (cp_new >= 16'hD800 && cp_new <= 16'hDFFF)) begin
              dec_o.count             = 2'd1;
              dec_o.res[0].last       = 1'b1;
              dec_o.res[0].kind       = KIND_ERROR;
              dec_o.res[0].error_kind = ERR_BAD_UNICODE;
              phase_d                 = PH_ERR;
            end else begin
              phase_d = PH_BODY;
              if (cp_new <= 16'h007F) begin
                dec_o.count           = 2'd1;
                dec_o.res[0].out_byte = cp_new[7:0];
                dec_o.res[0].last     = 1'b1;
              end else if (cp_new <= 16'h07FF) begin
                dec_o.count           = 2'd2;
                dec_o.res[0].out_byte = {3'b110, cp_new[10:6]};
                dec_o.res[1].out_byte = {2'b10, cp_new[5:0]};
                dec_o.res[1].last     = 1'b1;
              end else begin
                dec_o.count           = 2'd3;
                dec_o.res[0].out_byte = {4'b1110, cp_new[15:12]};
                dec_o.res[1].out_byte = {2'b10, cp_new[11:6]};
                dec_o.res[2].out_byte = {2'b10, cp_new[5:0]};
                dec_o.res[2].last     = 1'b1;
              end
            end
          end
        end
      end

      PH_ERR: begin
        if (end_of_input_i) begin
          phase_d = PH_IDLE;
        end
      end

      default: begin
        // Idle: wait for the opening quote
        phase_d = PH_IDLE;
        if (!end_of_input_i) begin
          if (data_byte_i == ChQuote) begin
            phase_d = PH_BODY;
          end else begin
            dec_o.count             = 2'd1;
            dec_o.res[0].last       = 1'b1;
            dec_o.res[0].kind       = KIND_ERROR;
            dec_o.res[0].error_kind = ERR_NO_OPEN_QUOTE;
            phase_d                 = PH_ERR;
          end
        end
      end
    endcase
  end

  // Advance state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      hex_count_q  <= '0;
      code_point_q <= '0;
      hex_bad_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      hex_count_q  <= hex_count_d;
      code_point_q <= code_point_d;
      hex_bad_q    <= hex_bad_d;
    end
  end

endmodule

`default_nettype wire

@@ design/json_string_unescape_utf8_top.sv @@
`default_nettype none

// Channel | Handshake              | Payload
// in      | in_valid_i, in_ready_o  | data_byte_i, end_of_input_i
// out     | out_valid_o, out_ready_i| out_byte_o, kind_o, error_kind_o, last_o
//
// One input request is taken per cycle while in_ready_o is high; its results
// enter a four-entry result queue at the edge that accepts it and leave one
// per cycle, while out_ready_i is high, from the next cycle on.
// A \u escape yields up to three results, so after it input pauses while
// the queue drains; the queue size sets how long the pause lasts.
// in_ready_o is high while at most one result is queued.
// Reset (rst_ni low) clears the decoder state and empties the queue.

module json_string_unescape_utf8_top
  import jsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_input_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      kind_o,
  output logic [2:0]      error_kind_o,
  output logic            last_o
);

  dec_out_t dec;
  logic     in_accept;
  logic     out_pop;

  result_t [QueueDepth-1:0] queue_q;
  logic [QueueIdxW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QueueIdxW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]     count_q, count_d;
  logic [QueueCntW-1:0]     push_n;

  assign in_ready_o = (count_q <= QueueCntW'(QueueDepth - MaxResults));
  assign in_accept  = in_valid_i & in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_pop     = out_valid_o & out_ready_i;

  jsu_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .dec_o          (dec)
  );

  // Queue pointers and fill level
  always_comb begin
    push_n   = in_accept ? QueueCntW'(dec.count) : '0;
    wr_ptr_d = wr_ptr_q + QueueIdxW'(push_n);
    rd_ptr_d = rd_ptr_q + QueueIdxW'(out_pop);
    count_d  = count_q + push_n - QueueCntW'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the results of an accepted request
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) begin
      if (in_accept && (2'(i) < dec.count)) begin
        queue_q[wr_ptr_q + QueueIdxW'(i)] <= dec.res[i];
      end
    end
  end

  // Drive the head of the queue
  assign out_byte_o   = queue_q[rd_ptr_q].out_byte;
  assign kind_o       = queue_q[rd_ptr_q].kind;
  assign error_kind_o = queue_q[rd_ptr_q].error_kind;
  assign last_o       = queue_q[rd_ptr_q].last;

endmodule

`default_nettype wire
